// File: design/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
// No dependencies; imported by every module of the block.
package mme_pkg;

	// Request kinds carried on the input tuser field
	localparam int REQ_W = 2;
	localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ROW    = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

	// Entries of the command queue between front and back
	localparam int CMD_FIFO_DEPTH = 4;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE  = 3'b001,
		BK_RUN   = 3'b010,
		BK_DRAIN = 3'b100
	} back_state_t;

endpackage

// File: design/mme_front.sv
// Front end: dimension registers, input handshake and request screening.
// Depends on mme_pkg.
module mme_front #(
	parameter int MAX_DIM = 32,
	parameter int IDX_W   = 5,
	parameter int REG_W   = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beat fields
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mme_pkg::REQ_W-1:0]     in_kind,
	input  logic [IDX_W-1:0]              in_row,
	input  logic [IDX_W-1:0]              in_col,
	// command queue write side
	input  logic                          cmd_full,
	output logic                          cmd_push,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [REG_W-1:0]              cfg_wdata,
	// dimensions for the back end
	output logic [REG_W-1:0]              inner_dim,
	output logic [REG_W-1:0]              cols_b
);
	import mme_pkg::*;

	logic [REG_W-1:0] rows_a_q;
	logic [REG_W-1:0] inner_dim_q;
	logic [REG_W-1:0] cols_b_q;
	logic [REG_W-1:0] cfg_clamped;
	logic             in_store;
	logic             keep;

	// Zero reads as one, anything above the store size saturates
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_clamped = REG_W'(1);
		end else if (cfg_wdata > REG_W'(MAX_DIM)) begin
			cfg_clamped = REG_W'(MAX_DIM);
		end else begin
			cfg_clamped = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= REG_W'(MAX_DIM);
			inner_dim_q <= REG_W'(MAX_DIM);
			cols_b_q    <= REG_W'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_ROWS_A:    rows_a_q    <= cfg_clamped;
				CFG_INNER_DIM: inner_dim_q <= cfg_clamped;
				CFG_COLS_B:    cols_b_q    <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// Loads must land inside the store; row requests inside the product
	assign in_store = ({1'b0, in_row} < (IDX_W+1)'(MAX_DIM)) &&
	                  ({1'b0, in_col} < (IDX_W+1)'(MAX_DIM));

	always_comb begin
		unique case (in_kind)
			REQ_LOAD_A, REQ_LOAD_B: keep = in_store;
			REQ_ROW:                keep = (REG_W'(in_row) < rows_a_q);
			default:                keep = 1'b0;
		endcase
	end

	assign in_ready  = !cmd_full;
	assign cmd_push  = in_valid && in_ready && keep;
	assign inner_dim = inner_dim_q;
	assign cols_b    = cols_b_q;

endmodule

// File: design/mme_fifo.sv
// Small command queue that decouples the front end from the back end.
// Show-ahead read; depends on mme_pkg only for the common import style.
module mme_fifo #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	import mme_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/mme_back.sv
// Back end: element stores, multiply-accumulate sequencer and output register.
// Depends on mme_pkg.
module mme_back #(
	parameter int ELEM_WIDTH = 16,
	parameter int IDX_W      = 5,
	parameter int REG_W      = 6,
	parameter int PROD_W     = 37
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// command queue read side
	input  logic                      cmd_empty,
	output logic                      cmd_pop,
	input  logic [mme_pkg::REQ_W-1:0] cmd_kind,
	input  logic [IDX_W-1:0]          cmd_row,
	input  logic [IDX_W-1:0]          cmd_col,
	input  logic [ELEM_WIDTH-1:0]     cmd_value,
	// dimensions
	input  logic [REG_W-1:0]          inner_dim,
	input  logic [REG_W-1:0]          cols_b,
	// result beat
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [IDX_W-1:0]          out_row,
	output logic [IDX_W-1:0]          out_col,
	output logic [PROD_W-1:0]         out_value,
	output logic                      out_last
);
	import mme_pkg::*;

	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int MUL_W  = 2 * ELEM_WIDTH;

	logic [ELEM_WIDTH-1:0]    store_a [DEPTH];
	logic [ELEM_WIDTH-1:0]    store_b [DEPTH];

	back_state_t              state_q;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         l_q;
	logic [IDX_W-1:0]         j_q;
	logic signed [PROD_W-1:0] acc_q;

	logic                     v_s1;
	logic signed [ELEM_WIDTH-1:0] a_s1;
	logic signed [ELEM_WIDTH-1:0] b_s1;
	logic                     v_s2;
	logic signed [MUL_W-1:0]  prod_s2;

	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_row_q;
	logic [IDX_W-1:0]         out_col_q;
	logic [PROD_W-1:0]        out_value_q;
	logic                     out_last_q;

	logic                     issue;
	logic                     l_end;
	logic                     j_end;
	logic                     drained;
	logic                     out_free;
	logic                     emit;
	logic [REG_W-1:0]         inner_m1;
	logic [REG_W-1:0]         cols_m1;

	assign inner_m1 = inner_dim - REG_W'(1);
	assign cols_m1  = cols_b - REG_W'(1);
	assign l_end    = (REG_W'(l_q) == inner_m1);
	assign j_end    = (REG_W'(j_q) == cols_m1);
	assign issue    = (state_q == BK_RUN);
	assign drained  = !v_s1 && !v_s2;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == BK_DRAIN) && drained && out_free;
	assign cmd_pop  = (state_q == BK_IDLE) && !cmd_empty;

	// Element stores: loads write, the sequencer reads one term per cycle
	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd_kind == REQ_LOAD_A)) begin
			store_a[{cmd_row, cmd_col}] <= cmd_value;
		end
		if (cmd_pop && (cmd_kind == REQ_LOAD_B)) begin
			store_b[{cmd_row, cmd_col}] <= cmd_value;
		end
		a_s1 <= store_a[{row_q, l_q}];
		b_s1 <= store_b[{l_q, j_q}];
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// Accumulator; cleared at the start of every column
	always_ff @(posedge clk) begin
		priority if (v_s2) begin
			acc_q <= acc_q + {{(PROD_W-MUL_W){prod_s2[MUL_W-1]}}, prod_s2};
		end else if (cmd_pop || emit) begin
			acc_q <= '0;
		end
	end

	// Sequencer over columns and inner terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			row_q   <= '0;
			l_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (cmd_pop && (cmd_kind == REQ_ROW)) begin
						row_q   <= cmd_row;
						l_q     <= '0;
						j_q     <= '0;
						state_q <= BK_RUN;
					end
				end
				BK_RUN: begin
					if (l_end) begin
						l_q     <= '0;
						state_q <= BK_DRAIN;
					end else begin
						l_q <= l_q + 1'b1;
					end
				end
				BK_DRAIN: begin
					if (emit) begin
						if (j_end) begin
							state_q <= BK_IDLE;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= BK_RUN;
						end
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	// Output register holds a finished beat while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q   <= row_q;
			out_col_q   <= j_q;
			out_value_q <= acc_q;
			out_last_q  <= j_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

// File: design/matrix_multiply_engine_unit.sv
// Top level of the matrix multiply engine (C = A x B, Q8.8 in, Q21.16 out).
// Depends on mme_pkg, mme_front, mme_fifo and mme_back.
//
// Usage:
//   Input stream: tuser is the request kind (load A element, load B element,
//   emit product row); tdata carries row index, column index and element.
//   A row request produces cols_b output beats, one per product column in
//   column order, with tlast on the last column. Loads and requests that
//   fall outside the store or the configured rows produce nothing.
//   Configuration (rows_a, inner_dim, cols_b) is written through cfg_we,
//   cfg_addr and cfg_wdata while the block is idle; zero reads as one and
//   values above MAX_DIM saturate.
// Operation:
//   Each product column is computed on the single multiply-accumulate unit:
//   the stores are read, the product is registered and summed, and the beat
//   is registered once the pipeline drains. A four-entry command queue lets
//   loads be taken while a row is computed.
// Reset clears the dimension registers to MAX_DIM, the queue and all valid
// flags; element stores are not cleared. When the receiver stalls, the
// finished beat waits in the output register and the sequencer holds.
module matrix_multiply_engine_unit #(
	parameter int MAX_DIM    = 32,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// fields from bit 0: row_index, col_index, element_value, zero pad
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [((2*$clog2(MAX_DIM)+ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// fields from bit 0: req_type
	input  logic [mme_pkg::REQ_W-1:0]        s_axis_tuser,
	// fields from bit 0: out_row, out_col, product_value, zero pad
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [((3*$clog2(MAX_DIM)+2*ELEM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	output logic                             m_axis_tlast,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [mme_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [$clog2(MAX_DIM+1)-1:0]     cfg_wdata
);
	import mme_pkg::*;

	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int REG_W     = $clog2(MAX_DIM + 1);
	localparam int PROD_W    = 2 * ELEM_WIDTH + IDX_W;
	localparam int CMD_W     = REQ_W + 2 * IDX_W + ELEM_WIDTH;
	localparam int IN_BITS   = 2 * IDX_W + ELEM_WIDTH;
	localparam int OUT_BITS  = 2 * IDX_W + PROD_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	logic [IDX_W-1:0]      in_row;
	logic [IDX_W-1:0]      in_col;
	logic [ELEM_WIDTH-1:0] in_value;
	logic                  cmd_push;
	logic                  cmd_full;
	logic                  cmd_pop;
	logic                  cmd_empty;
	logic [CMD_W-1:0]      cmd_wr;
	logic [CMD_W-1:0]      cmd_rd;
	logic [REG_W-1:0]      inner_dim;
	logic [REG_W-1:0]      cols_b;
	logic [IDX_W-1:0]      out_row;
	logic [IDX_W-1:0]      out_col;
	logic [PROD_W-1:0]     out_value;

	// unpack the input beat
	assign in_row   = s_axis_tdata[IDX_W-1:0];
	assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign in_value = s_axis_tdata[IN_BITS-1:2*IDX_W];

	mme_front #(
		.MAX_DIM (MAX_DIM),
		.IDX_W   (IDX_W),
		.REG_W   (REG_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_row    (in_row),
		.in_col    (in_col),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.inner_dim (inner_dim),
		.cols_b    (cols_b)
	);

	assign cmd_wr = {in_value, in_col, in_row, s_axis_tuser};

	mme_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	mme_back #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.IDX_W      (IDX_W),
		.REG_W      (REG_W),
		.PROD_W     (PROD_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd_kind  (cmd_rd[REQ_W-1:0]),
		.cmd_row   (cmd_rd[REQ_W+IDX_W-1:REQ_W]),
		.cmd_col   (cmd_rd[REQ_W+2*IDX_W-1:REQ_W+IDX_W]),
		.cmd_value (cmd_rd[CMD_W-1:REQ_W+2*IDX_W]),
		.inner_dim (inner_dim),
		.cols_b    (cols_b),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.out_last  (m_axis_tlast)
	);

	// pack the result beat
	assign m_axis_tdata = OUT_DATA_W'({out_value, out_col, out_row});

endmodule

// File: design/mme_checker.sv
// Port-level checker for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg and matrix_multiply_engine_unit.
module mme_checker #(
	parameter int MAX_DIM    = 32,
	parameter int ELEM_WIDTH = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [((3*$clog2(MAX_DIM)+2*ELEM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input logic                             m_axis_tlast,
	input logic                             cfg_we,
	input logic [mme_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input logic [$clog2(MAX_DIM+1)-1:0]     cfg_wdata
);
	import mme_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int REG_W = $clog2(MAX_DIM + 1);

	logic [REG_W-1:0] cols_q;
	logic [REG_W-1:0] cols_next;
	logic [REG_W-1:0] beat_col;
	logic             out_beat;

	// shadow of the column count as seen on the configuration port
	always_comb begin
		if (cfg_wdata == '0) begin
			cols_next = REG_W'(1);
		end else if (cfg_wdata > REG_W'(MAX_DIM)) begin
			cols_next = REG_W'(MAX_DIM);
		end else begin
			cols_next = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= REG_W'(MAX_DIM);
		end else if (cfg_we && (cfg_addr == CFG_COLS_B)) begin
			cols_q <= cols_next;
		end
	end

	assign beat_col = REG_W'(m_axis_tdata[2*IDX_W-1:IDX_W]);
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// a stalled result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// the marked beat is the last configured column
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && m_axis_tlast |-> beat_col == cols_q - REG_W'(1))
		else $error("tlast on wrong column");

	// no beat names a column beyond the configured width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> beat_col < cols_q)
		else $error("result column out of range");

	// nothing is offered right after reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid right after reset");

endmodule

bind matrix_multiply_engine_unit mme_checker #(
	.MAX_DIM    (MAX_DIM),
	.ELEM_WIDTH (ELEM_WIDTH)
) u_mme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.cfg_we        (cfg_we),
	.cfg_addr      (cfg_addr),
	.cfg_wdata     (cfg_wdata)
);
